[rtl/ftrc_pkg.sv]
// Shared types and constants for the fan temperature rise controller.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package ftrc_pkg;

	localparam int TEMP_W  = 12;
	localparam int RATE_W  = 16;
	localparam int TIME_W  = 32;
	localparam int MIN_W   = 8;
	localparam int HOLD_W  = 24;	// minimum_minutes * 60000 fits 24 bits
	localparam int WIN_DEPTH = 5;
	localparam int CNT_W   = 3;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_INITIAL = 2'd1,
		MODE_WAITING = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_SAMPLE        = 2'd0,
		CMD_FORCE_IDLE    = 2'd1,
		CMD_FORCE_INITIAL = 2'd2,
		CMD_FORCE_WAITING = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ON_TEMPERATURE  = 2'd0,
		REG_OFF_TEMPERATURE = 2'd1,
		REG_ON_RATE         = 2'd2,
		REG_MINIMUM_MINUTES = 2'd3
	} reg_idx_t;

	localparam logic signed [TEMP_W-1:0] ON_TEMPERATURE_RST  = 12'sd400;
	localparam logic signed [TEMP_W-1:0] OFF_TEMPERATURE_RST = 12'sd368;
	localparam logic signed [RATE_W-1:0] ON_RATE_RST         = 16'sd160;
	localparam logic [MIN_W-1:0]         MINIMUM_MINUTES_RST = 8'd5;

endpackage

[rtl/ftrc_if.sv]
// Valid/ready channel interfaces: one for input items, one for result items.
// Depends on ftrc_pkg for field widths.
`timescale 1ns / 1ps

interface ftrc_item_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             cmd;
	logic signed [ftrc_pkg::TEMP_W-1:0]     temperature;
	logic [ftrc_pkg::TIME_W-1:0]            now_ms;

	modport source (output valid, cmd, temperature, now_ms, input ready);
	modport sink   (input valid, cmd, temperature, now_ms, output ready);
endinterface

interface ftrc_result_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   fan_on;
	logic [1:0]                             mode;
	logic signed [ftrc_pkg::RATE_W-1:0]     rise_rate;

	modport source (output valid, fan_on, mode, rise_rate, input ready);
	modport sink   (input valid, fan_on, mode, rise_rate, output ready);
endinterface

[rtl/ftrc_window.sv]
// Five-sample temperature window and the saturated five-point rise estimate.
// Depends on ftrc_pkg. Rise output reflects the window after this cycle's shift.
`timescale 1ns / 1ps

module ftrc_window (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift_en,
	input  logic signed [ftrc_pkg::TEMP_W-1:0]  temperature,
	output logic signed [ftrc_pkg::RATE_W-1:0]  rise_rate
);
	import ftrc_pkg::*;

	localparam int SUM_W = TEMP_W + 6;

	// entry 0 is the oldest sample once the window is full
	logic signed [TEMP_W-1:0] win_q [WIN_DEPTH];
	logic signed [TEMP_W-1:0] win_d [WIN_DEPTH];
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_d;
	logic signed [SUM_W-1:0]  sum;

	always_comb begin
		for (int i = 0; i < WIN_DEPTH - 1; i++) begin
			win_d[i] = shift_en ? win_q[i+1] : win_q[i];
		end
		win_d[WIN_DEPTH-1] = shift_en ? temperature : win_q[WIN_DEPTH-1];
		cnt_d = (shift_en && cnt_q != CNT_W'(WIN_DEPTH)) ? cnt_q + CNT_W'(1) : cnt_q;
	end

	always_comb begin
		sum = SUM_W'(win_d[0]) - (SUM_W'(win_d[1]) <<< 3)
		    + (SUM_W'(win_d[3]) <<< 3) - SUM_W'(win_d[4]);
		if (cnt_d != CNT_W'(WIN_DEPTH)) begin
			rise_rate = '0;
		end else if (sum > SUM_W'(32767)) begin
			rise_rate = 16'sh7FFF;
		end else if (sum < -SUM_W'(32768)) begin
			rise_rate = -16'sh8000;
		end else begin
			rise_rate = RATE_W'(sum);
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WIN_DEPTH))
		else $error("sample count beyond window depth");

	a_rise_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		rise_rate != '0 |-> cnt_d == CNT_W'(WIN_DEPTH))
		else $error("rise estimate before window is full");
endmodule

[rtl/fan_temperature_rise_controller.sv]
// Top level: APB register file, input stage, mode/fan control and result register.
// Depends on ftrc_pkg, ftrc_if.sv and ftrc_window.
// Path: input register, then result register; both hold while a result is pending and result.ready is low.
// Throughput: one transaction per cycle while results are drained; the next item sees the mode of the previous one.
// Reset (arst_n low, asynchronous): mode idle, fan off, timer 0, window empty, registers default.
`timescale 1ns / 1ps

module fan_temperature_rise_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	ftrc_item_if.sink                     item,
	ftrc_result_if.source                 result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ftrc_pkg::ADDR_W-1:0]   paddr,
	input  logic [ftrc_pkg::DATA_W-1:0]   pwdata,
	output logic [ftrc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import ftrc_pkg::*;

	// configuration registers
	logic signed [TEMP_W-1:0] on_temperature_q;
	logic signed [TEMP_W-1:0] off_temperature_q;
	logic signed [RATE_W-1:0] on_rate_q;
	logic [MIN_W-1:0]         minimum_minutes_q;
	reg_idx_t                 reg_idx;

	// input stage
	logic                     valid_s1;
	cmd_t                     cmd_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic [TIME_W-1:0]        now_s1;

	// control state and result register
	mode_t                    mode_q, mode_d;
	logic                     fan_q, fan_d;
	logic [TIME_W-1:0]        start_q, start_d;
	logic                     res_valid_q;
	logic                     res_fan_q;
	mode_t                    res_mode_q;
	logic signed [RATE_W-1:0] res_rise_q;

	logic                     advance;
	logic                     step;
	logic signed [RATE_W-1:0] rise_next;
	logic [TIME_W-1:0]        elapsed;
	logic [HOLD_W-1:0]        hold_ms;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_temperature_q  <= ON_TEMPERATURE_RST;
			off_temperature_q <= OFF_TEMPERATURE_RST;
			on_rate_q         <= ON_RATE_RST;
			minimum_minutes_q <= MINIMUM_MINUTES_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_ON_TEMPERATURE:  on_temperature_q  <= pwdata[TEMP_W-1:0];
				REG_OFF_TEMPERATURE: off_temperature_q <= pwdata[TEMP_W-1:0];
				REG_ON_RATE:         on_rate_q         <= pwdata[RATE_W-1:0];
				REG_MINIMUM_MINUTES: minimum_minutes_q <= pwdata[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ON_TEMPERATURE:  prdata = DATA_W'(on_temperature_q);
			REG_OFF_TEMPERATURE: prdata = DATA_W'(off_temperature_q);
			REG_ON_RATE:         prdata = DATA_W'(on_rate_q);
			REG_MINIMUM_MINUTES: prdata = DATA_W'(minimum_minutes_q);
			default:             prdata = '0;
		endcase
	end

	// stage 1 moves on when the result register is empty or being drained
	assign advance    = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			cmd_s1  <= cmd_t'(item.cmd);
			temp_s1 <= item.temperature;
			now_s1  <= item.now_ms;
		end
	end

	ftrc_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.shift_en    (step && cmd_s1 == CMD_SAMPLE),
		.temperature (temp_s1),
		.rise_rate   (rise_next)
	);

	assign elapsed = now_s1 - start_q;
	assign hold_ms = HOLD_W'(minimum_minutes_q) * HOLD_W'(MS_PER_MINUTE);

	// A rise force leaves elapsed time at zero, so the initial rule cannot fire after it;
	// the mode rule therefore only runs on the old state when no force happened.
	always_comb begin
		mode_d  = mode_q;
		fan_d   = fan_q;
		start_d = start_q;
		unique case (cmd_s1)
			CMD_SAMPLE: begin
				if (rise_next > on_rate_q) begin
					mode_d  = MODE_INITIAL;
					fan_d   = 1'b1;
					start_d = now_s1;
				end else begin
					unique case (mode_q)
						MODE_IDLE: begin
							if (temp_s1 > on_temperature_q) begin
								mode_d  = MODE_INITIAL;
								fan_d   = 1'b1;
								start_d = now_s1;
							end
						end
						MODE_INITIAL: begin
							if (elapsed > TIME_W'(hold_ms)) begin
								mode_d = MODE_WAITING;
							end
						end
						MODE_WAITING: begin
							if (temp_s1 < off_temperature_q) begin
								mode_d = MODE_IDLE;
								fan_d  = 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
			CMD_FORCE_IDLE: begin
				mode_d = MODE_IDLE;
				fan_d  = 1'b0;
			end
			CMD_FORCE_INITIAL: begin
				mode_d  = MODE_INITIAL;
				fan_d   = 1'b1;
				start_d = now_s1;
			end
			CMD_FORCE_WAITING: begin
				mode_d = MODE_WAITING;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			fan_q       <= 1'b0;
			start_q     <= '0;
			res_valid_q <= 1'b0;
			res_fan_q   <= 1'b0;
			res_mode_q  <= MODE_IDLE;
			res_rise_q  <= '0;
		end else begin
			if (advance) begin
				res_valid_q <= valid_s1;
			end
			if (step) begin
				mode_q     <= mode_d;
				fan_q      <= fan_d;
				start_q    <= start_d;
				res_fan_q  <= fan_d;
				res_mode_q <= mode_d;
				res_rise_q <= rise_next;
			end
		end
	end

	assign result.valid     = res_valid_q;
	assign result.fan_on    = res_fan_q;
	assign result.mode      = res_mode_q;
	assign result.rise_rate = res_rise_q;

	a_idle_fan_off: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> !fan_q)
		else $error("fan on while idle");

	a_initial_fan_on: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_INITIAL |-> fan_q)
		else $error("fan off while in initial mode");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("result produced without a staged item");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> res_mode_q == mode_q && res_fan_q == fan_q)
		else $error("result register disagrees with control state");
endmodule
